[hdl/dleb_pkg.sv]
// ----------------------------------------------------------------------------
// dleb_pkg
// Shared constants for the delay-line event builder: register map, register
// reset values and default time width.
// ----------------------------------------------------------------------------
package dleb_pkg;

    localparam int TIME_WIDTH_DEF = 48;
    localparam int HIT_TIME_W     = 48;
    localparam int DIFF_W         = 49;
    localparam int CFG_W          = 32;
    localparam int N_CFG          = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int N_SIG          = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_XGATE_X_LOW  = 3'd0,
        CFG_XGATE_X_HIGH = 3'd1,
        CFG_XGATE_Y_LOW  = 3'd2,
        CFG_XGATE_Y_HIGH = 3'd3,
        CFG_YGATE_Y_LOW  = 3'd4,
        CFG_YGATE_Y_HIGH = 3'd5,
        CFG_YGATE_X_LOW  = 3'd6,
        CFG_YGATE_X_HIGH = 3'd7
    } cfg_idx_t;

    localparam logic signed [CFG_W-1:0] XGATE_X_LOW_RST  = -32'sd10000;
    localparam logic signed [CFG_W-1:0] XGATE_X_HIGH_RST = 32'sd50000;
    localparam logic signed [CFG_W-1:0] XGATE_Y_LOW_RST  = -32'sd16000;
    localparam logic signed [CFG_W-1:0] XGATE_Y_HIGH_RST = -32'sd4000;
    localparam logic signed [CFG_W-1:0] YGATE_Y_LOW_RST  = -32'sd30000;
    localparam logic signed [CFG_W-1:0] YGATE_Y_HIGH_RST = 32'sd10000;
    localparam logic signed [CFG_W-1:0] YGATE_X_LOW_RST  = 32'sd10000;
    localparam logic signed [CFG_W-1:0] YGATE_X_HIGH_RST = 32'sd35000;

endpackage

[hdl/delay_line_event_builder.sv]
// Output: a trigger hit that follows an earlier trigger closes the earlier trigger's
//   record into the output register; other hits only update internal state.
// Throughput: one hit per cycle; s_ready drops only while a record is held
//   and m_ready is low (single output register).
// Reset: synchronous, active low; clears seen flags, trigger stamp, gate
//   registers to defaults and the output valid. Latched hit times are not reset.
// ----------------------------------------------------------------------------
// delay_line_event_builder
// Builds one record per trigger, closed when the next trigger arrives, from the
// first hit on each MCP delay-line channel: differences, window gates, trigger interval.
// ----------------------------------------------------------------------------
module delay_line_event_builder #(
    parameter int TIME_WIDTH = dleb_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_board_id,
    input  logic [5:0]                           s_channel_id,
    input  logic [dleb_pkg::HIT_TIME_W-1:0]      s_hit_time,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dleb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dleb_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_mcp1_complete,
    output logic                                 m_mcp2_complete,
    output logic                                 m_mcp2_timing_seen,
    output logic signed [dleb_pkg::DIFF_W-1:0]   m_trigger_to_t2,
    output logic signed [dleb_pkg::DIFF_W-1:0]   m_mcp1_x_diff,
    output logic signed [dleb_pkg::DIFF_W-1:0]   m_mcp1_y_diff,
    output logic signed [dleb_pkg::DIFF_W-1:0]   m_mcp2_x_diff,
    output logic signed [dleb_pkg::DIFF_W-1:0]   m_mcp2_y_diff,
    output logic [3:0]                           m_gate_flags,
    output logic                                 m_event_complete,
    output logic [dleb_pkg::HIT_TIME_W-1:0]      m_trigger_interval
);

    // stored time bits: the hit field caps the useful width
    localparam int EW = (TIME_WIDTH < dleb_pkg::HIT_TIME_W) ?
                        TIME_WIDTH : dleb_pkg::HIT_TIME_W;
    localparam int DW = dleb_pkg::DIFF_W;
    localparam int NL = dleb_pkg::N_SIG - 1;

    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [dleb_pkg::CFG_W-1:0] bound_t;

    bound_t                   cfg_reg [dleb_pkg::N_CFG];
    logic [EW-1:0]            latch_reg [NL];
    logic [EW-1:0]            stamp_reg;
    logic [dleb_pkg::N_SIG-1:0] seen_reg;

    logic                     out_valid_reg;
    logic                     c1_reg, c2_reg, t2_reg, ev_reg;
    diff_t                    tt_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [3:0]               gate_reg;
    logic [dleb_pkg::HIT_TIME_W-1:0] ival_reg;

    logic                     s_fire;
    logic                     is_trig;
    logic [3:0]               sig;
    logic [EW-1:0]            t_in;
    logic                     c1_next, c2_next, t2_next;
    diff_t                    tt_next, x1_next, y1_next, x2_next, y2_next;
    logic [3:0]               gate_next;
    logic [dleb_pkg::HIT_TIME_W-1:0] ival_next;

    function automatic logic [3:0] sig_of(input logic [1:0] b, input logic [5:0] c);
        logic [3:0] s;
        s = 4'd0;
        unique case (b)
            2'd0: begin
                if (c <= 6'd7) begin
                    s = 4'(c);
                end
            end
            2'd1: begin
                if (c <= 6'd1) begin
                    s = 4'(c) + 4'd8;
                end
            end
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic diff_t tsub(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic signed [EW:0] d;
        d = signed'({1'b0, a}) - signed'({1'b0, b});
        return DW'(d);
    endfunction

    function automatic logic in_win(input diff_t v, input bound_t lo, input bound_t hi);
        return (v > DW'(lo)) && (v < DW'(hi));
    endfunction

    function automatic logic [1:0] gates(input diff_t dx, input diff_t dy,
                                         input bound_t c [dleb_pkg::N_CFG]);
        logic [1:0] g;
        g[0] = in_win(dx, c[dleb_pkg::CFG_XGATE_X_LOW], c[dleb_pkg::CFG_XGATE_X_HIGH])
            && in_win(dy, c[dleb_pkg::CFG_XGATE_Y_LOW], c[dleb_pkg::CFG_XGATE_Y_HIGH]);
        g[1] = in_win(dx, c[dleb_pkg::CFG_YGATE_X_LOW], c[dleb_pkg::CFG_YGATE_X_HIGH])
            && in_win(dy, c[dleb_pkg::CFG_YGATE_Y_LOW], c[dleb_pkg::CFG_YGATE_Y_HIGH]);
        return g;
    endfunction

    assign s_ready   = !out_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign is_trig   = (s_board_id == 2'd0) && (s_channel_id == 6'd0);
    assign sig       = sig_of(s_board_id, s_channel_id);
    assign t_in      = s_hit_time[EW-1:0];

    always_comb begin
        diff_t dx1, dy1, dx2, dy2;
        dx1 = tsub(latch_reg[0], latch_reg[1]);
        dy1 = tsub(latch_reg[2], latch_reg[3]);
        dx2 = tsub(latch_reg[5], latch_reg[6]);
        dy2 = tsub(latch_reg[7], latch_reg[8]);
        c1_next   = &seen_reg[4:0];
        c2_next   = &seen_reg[9:5];
        t2_next   = seen_reg[5];
        tt_next   = t2_next ? tsub(stamp_reg, latch_reg[4]) : '0;
        x1_next   = c1_next ? dx1 : '0;
        y1_next   = c1_next ? dy1 : '0;
        x2_next   = c2_next ? dx2 : '0;
        y2_next   = c2_next ? dy2 : '0;
        gate_next = {c2_next ? gates(dx2, dy2, cfg_reg) : 2'b00,
                     c1_next ? gates(dx1, dy1, cfg_reg) : 2'b00};
        ival_next = dleb_pkg::HIT_TIME_W'(EW'(t_in - stamp_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[dleb_pkg::CFG_XGATE_X_LOW]  <= dleb_pkg::XGATE_X_LOW_RST;
            cfg_reg[dleb_pkg::CFG_XGATE_X_HIGH] <= dleb_pkg::XGATE_X_HIGH_RST;
            cfg_reg[dleb_pkg::CFG_XGATE_Y_LOW]  <= dleb_pkg::XGATE_Y_LOW_RST;
            cfg_reg[dleb_pkg::CFG_XGATE_Y_HIGH] <= dleb_pkg::XGATE_Y_HIGH_RST;
            cfg_reg[dleb_pkg::CFG_YGATE_Y_LOW]  <= dleb_pkg::YGATE_Y_LOW_RST;
            cfg_reg[dleb_pkg::CFG_YGATE_Y_HIGH] <= dleb_pkg::YGATE_Y_HIGH_RST;
            cfg_reg[dleb_pkg::CFG_YGATE_X_LOW]  <= dleb_pkg::YGATE_X_LOW_RST;
            cfg_reg[dleb_pkg::CFG_YGATE_X_HIGH] <= dleb_pkg::YGATE_X_HIGH_RST;
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg     <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire && is_trig && seen_reg[0]) begin
                out_valid_reg <= 1'b1;
            end else if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (s_fire) begin
                if (is_trig) begin
                    stamp_reg <= t_in;
                    seen_reg  <= dleb_pkg::N_SIG'(1);
                end else if (sig != 4'd0 && !seen_reg[sig]) begin
                    seen_reg[sig] <= 1'b1;
                end
            end
        end
    end

    // hit latches and record payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire && !is_trig && sig != 4'd0 && !seen_reg[sig]) begin
            latch_reg[sig - 4'd1] <= t_in;
        end
        if (s_fire && is_trig && seen_reg[0]) begin
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            t2_reg   <= t2_next;
            ev_reg   <= c1_next && c2_next;
            tt_reg   <= tt_next;
            x1_reg   <= x1_next;
            y1_reg   <= y1_next;
            x2_reg   <= x2_next;
            y2_reg   <= y2_next;
            gate_reg <= gate_next;
            ival_reg <= ival_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_mcp1_complete    = c1_reg;
    assign m_mcp2_complete    = c2_reg;
    assign m_mcp2_timing_seen = t2_reg;
    assign m_trigger_to_t2    = tt_reg;
    assign m_mcp1_x_diff      = x1_reg;
    assign m_mcp1_y_diff      = y1_reg;
    assign m_mcp2_x_diff      = x2_reg;
    assign m_mcp2_y_diff      = y2_reg;
    assign m_gate_flags       = gate_reg;
    assign m_event_complete   = ev_reg;
    assign m_trigger_interval = ival_reg;

endmodule

[hdl/dleb_checker.sv]
// ----------------------------------------------------------------------------
// dleb_checker
// Port-level checks on the event builder's record output.
// ----------------------------------------------------------------------------
module dleb_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_mcp1_complete,
    input logic                                 m_mcp2_complete,
    input logic                                 m_mcp2_timing_seen,
    input logic signed [dleb_pkg::DIFF_W-1:0]   m_trigger_to_t2,
    input logic signed [dleb_pkg::DIFF_W-1:0]   m_mcp1_x_diff,
    input logic signed [dleb_pkg::DIFF_W-1:0]   m_mcp1_y_diff,
    input logic [3:0]                           m_gate_flags,
    input logic                                 m_event_complete,
    input logic [dleb_pkg::HIT_TIME_W-1:0]      m_trigger_interval
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("record valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_trigger_interval)
            && $stable(m_gate_flags))
        else $error("record changed while stalled");

    a_complete_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_complete == (m_mcp1_complete && m_mcp2_complete))
            && (!m_mcp2_complete || m_mcp2_timing_seen))
        else $error("completeness flags inconsistent");

    a_invalid_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_mcp1_complete |-> m_mcp1_x_diff == '0 && m_mcp1_y_diff == '0
            && m_gate_flags[1:0] == 2'b00)
        else $error("incomplete MCP1 fields not zero");

    a_t2_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_mcp2_timing_seen |-> m_trigger_to_t2 == '0
            && m_gate_flags[3:2] == 2'b00)
        else $error("trigger to T2 set without T2");

endmodule

bind delay_line_event_builder dleb_checker u_dleb_checker (.*);
